FILE: design/cmeb_pkg.sv
// ----------------------------------------------------------------------------
// cmeb_pkg
// Shared types, constants and helpers for the chain model entropy builder.
// ----------------------------------------------------------------------------
package cmeb_pkg;

  localparam int MAX_VARS_DEF = 64;
  localparam int MAX_ROWS_DEF = 256;

  localparam int CFG_W = 17;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [29:0] LN2_Q30  = 30'd744261118;

  localparam logic [6:0]  NUM_VARS_RST = 7'd64;
  localparam logic [8:0]  SEL_SIZE_RST = 9'd256;
  localparam logic [16:0] FLOOR_RST    = 17'd0;
  localparam logic [16:0] CEIL_RST     = 17'd65536;

  typedef enum logic [1:0] {
    REG_NUM_VARS,
    REG_SEL_SIZE,
    REG_PROB_FLOOR,
    REG_PROB_CEIL
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  position;
    logic [5:0]  variable;
    logic [16:0] p_zero;
    logic [16:0] p_one;
    logic        last;
  } item_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_ROOT_NEXT,
    B_ROOT_SCAN,
    B_ROOT_EVAL,
    B_INIT,
    B_ROOT_DIV,
    B_ROOT_DIV_WAIT,
    B_ROOT_EMIT,
    B_NEXT_J,
    B_RD_WAIT,
    B_PAIR_SCAN,
    B_ENT,
    B_ENT_WAIT,
    B_CAND,
    B_DIV0,
    B_DIV0_WAIT,
    B_DIV1,
    B_DIV1_WAIT,
    B_SWAP_I,
    B_SWAP_C,
    B_EMIT
  } bld_state_t;

  typedef enum logic [2:0] {
    X_IDLE,
    X_SQ,
    X_MUL1,
    X_LN,
    X_MUL2,
    X_DONE
  } xl_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dv_state_t;

  function automatic logic [16:0] clip_q16(input logic [16:0] p, input logic [16:0] lo,
                                           input logic [16:0] hi);
    logic [16:0] r;
    r = p;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: design/chain_model_entropy_builder.sv
// Loading: one row transfer per cycle while no model is being built.
// Build: a row scan per variable and a MAX_VARS-entry order table init for the root,
//   then per candidate pair a row scan plus six serial x*ln(x) evaluations, and two
//   divisions per chain position (one for the root).
// Results: one per chain position, via a two-entry queue; rows are stalled during a build.
// Reset (rst, synchronous): row count cleared, registers to defaults, queue emptied.
// ----------------------------------------------------------------------------
// chain_model_entropy_builder
// Collects bit-vector rows and builds a greedy conditional-entropy chain model.
// ----------------------------------------------------------------------------
module chain_model_entropy_builder #(
  parameter int MAX_VARS = cmeb_pkg::MAX_VARS_DEF,
  parameter int MAX_ROWS = cmeb_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  cmeb_pkg::reg_idx_t         cfg_index,
  input  logic [cmeb_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [63:0]                row_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [5:0]                 position,
  output logic [5:0]                 variable,
  output logic [16:0]                prob_after_zero,
  output logic [16:0]                prob_after_one,
  output logic                       last_entry
);
  import cmeb_pkg::*;

  localparam int IW = $clog2(MAX_VARS + 1);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [6:0]  num_vars;
  logic [8:0]  selection_size;
  logic [16:0] prob_floor;
  logic [16:0] prob_ceiling;

  logic [IW-1:0] nv_sat;
  logic [CW-1:0] need;
  logic [16:0]   lo;
  logic [16:0]   hi;

  logic          busy;
  logic          start;
  logic [CW-1:0] n_rows;
  logic [RW-1:0] raddr;
  logic [63:0]   rdata;
  logic          q_full;
  logic          push;
  item_t         push_item;
  item_t         out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars       <= NUM_VARS_RST;
      selection_size <= SEL_SIZE_RST;
      prob_floor     <= FLOOR_RST;
      prob_ceiling   <= CEIL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_VARS:   num_vars       <= cfg_data[6:0];
        REG_SEL_SIZE:   selection_size <= cfg_data[8:0];
        REG_PROB_FLOOR: prob_floor     <= cfg_data;
        REG_PROB_CEIL:  prob_ceiling   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_vars < 7'd2) nv_sat = IW'(2);
    else if (32'(num_vars) > MAX_VARS) nv_sat = IW'(MAX_VARS);
    else nv_sat = IW'(num_vars);

    if (selection_size == '0) need = CW'(1);
    else if (32'(selection_size) > MAX_ROWS) need = CW'(MAX_ROWS);
    else need = CW'(selection_size);

    lo = (prob_floor > ONE_Q16) ? ONE_Q16 : prob_floor;
    hi = (prob_ceiling > ONE_Q16) ? ONE_Q16 : prob_ceiling;
  end

  cmeb_loader #(.MAX_ROWS(MAX_ROWS)) u_loader (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .row_bits(row_bits),
    .busy(busy), .need(need), .start(start), .n_rows(n_rows),
    .raddr(raddr), .rdata(rdata)
  );

  cmeb_builder #(.MAX_VARS(MAX_VARS), .MAX_ROWS(MAX_ROWS)) u_builder (
    .clk(clk), .rst(rst),
    .start(start), .n_rows(n_rows), .nv(nv_sat), .lo(lo), .hi(hi),
    .row_raddr(raddr), .row_rdata(rdata), .busy(busy),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  cmeb_outq u_outq (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item), .full(q_full),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  assign position        = out_item.position;
  assign variable        = out_item.variable;
  assign prob_after_zero = out_item.p_zero;
  assign prob_after_one  = out_item.p_one;
  assign last_entry      = out_item.last;

endmodule

FILE: design/cmeb_loader.sv
// ----------------------------------------------------------------------------
// cmeb_loader
// Front end: takes rows into the row store and starts a build on the last row.
// ----------------------------------------------------------------------------
module cmeb_loader #(
  parameter int MAX_ROWS = cmeb_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [63:0]                           row_bits,
  input  logic                                  busy,
  input  logic [$clog2(MAX_ROWS+1)-1:0]         need,
  output logic                                  start,
  output logic [$clog2(MAX_ROWS+1)-1:0]         n_rows,
  input  logic [(MAX_ROWS>1 ? $clog2(MAX_ROWS) : 1)-1:0] raddr,
  output logic [63:0]                           rdata
);
  import cmeb_pkg::*;

  localparam int CW = $clog2(MAX_ROWS+1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [63:0]   row_mem [MAX_ROWS];
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          accept;
  logic          complete;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign n_rows   = cnt + CW'(1);
  assign complete = (n_rows >= need);
  assign start    = accept && complete;

  always_comb begin
    cnt_next = cnt;
    if (accept) begin
      cnt_next = complete ? '0 : n_rows;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[cnt[RW-1:0]] <= row_bits;
    end
    rdata <= row_mem[raddr];
  end

endmodule

FILE: design/cmeb_xlnx.sv
// ----------------------------------------------------------------------------
// cmeb_xlnx
// Iterative x*ln(x), result Q14.16 at CW=9: log2 by repeated squaring, one step a cycle.
// ----------------------------------------------------------------------------
module cmeb_xlnx #(
  parameter int CW = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CW-1:0]        x,
  output logic                 done,
  output logic [CW+((CW>1)?$clog2(CW):1)+31-14-1:0] result
);
  import cmeb_pkg::*;

  localparam int KW = (CW > 1) ? $clog2(CW) : 1;
  localparam int LW = KW + 31;
  localparam int PW = CW + LW;

  xl_state_t     state;
  xl_state_t     state_next;
  logic [CW-1:0] xr;
  logic [KW-1:0] k;
  logic [KW-1:0] kf;
  logic [30:0]   m;
  logic [29:0]   frac;
  logic [4:0]    step;
  logic [59:0]   fl;
  logic [LW-1:0] ln;
  logic [61:0]   sq;
  logic [31:0]   sq_hi;
  logic [59:0]   fl_rnd;
  logic [LW-1:0] kln;
  logic [PW-1:0] prod;

  always_comb begin
    kf = '0;
    for (int b = 0; b < CW; b++) begin
      if (x[b]) kf = KW'(b);
    end
  end

  assign sq     = m * m;
  assign sq_hi  = sq[61:30];
  assign fl_rnd = fl + (60'd1 << 29);
  assign kln    = LW'(k) * LW'(LN2_Q30);
  assign prod   = PW'(xr) * PW'(ln) + (PW'(1) << 13);
  assign done   = (state == X_DONE);

  always_comb begin
    state_next = state;
    case (state)
      X_IDLE:  if (start) state_next = (x < CW'(2)) ? X_DONE : X_SQ;
      X_SQ:    if (step == 5'd30) state_next = X_MUL1;
      X_MUL1:  state_next = X_LN;
      X_LN:    state_next = X_MUL2;
      X_MUL2:  state_next = X_DONE;
      X_DONE:  state_next = X_IDLE;
      default: state_next = X_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= X_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      X_IDLE: begin
        xr     <= x;
        k      <= kf;
        m      <= 31'(x) << (5'd30 - 5'(kf));
        frac   <= '0;
        step   <= 5'd1;
        result <= '0;
      end
      X_SQ: begin
        frac <= {frac[28:0], sq_hi[31]};
        m    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
        step <= step + 5'd1;
      end
      X_MUL1: fl <= 60'(frac) * 60'(LN2_Q30);
      X_LN:   ln <= kln + LW'(fl_rnd[59:30]);
      X_MUL2: result <= prod[PW-1:14];
      default: ;
    endcase
  end

endmodule

FILE: design/cmeb_div.sv
// ----------------------------------------------------------------------------
// cmeb_div
// Restoring divider for (num << 16) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cmeb_div #(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] num,
  input  logic [CW-1:0] den,
  output logic          done,
  output logic [16:0]   quo
);
  import cmeb_pkg::*;

  localparam int NW = CW + 16;
  localparam int SW = $clog2(NW + 1);

  dv_state_t     state;
  dv_state_t     state_next;
  logic [NW-1:0] dividend;
  logic [NW-1:0] q;
  logic [CW-1:0] rem;
  logic [CW-1:0] d;
  logic [SW-1:0] cnt;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem, dividend[NW-1]};
  assign fits  = (trial >= {1'b0, d});
  assign quo   = q[16:0];
  assign done  = (state == D_DONE);

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE:  if (start) state_next = (den == '0) ? D_DONE : D_RUN;
      D_RUN:   if (cnt == SW'(1)) state_next = D_DONE;
      D_DONE:  state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        dividend <= {num, 16'd0};
        d        <= den;
        rem      <= '0;
        cnt      <= SW'(NW);
        q        <= (den == '0) ? NW'(HALF_Q16) : '0;
      end
      D_RUN: begin
        rem      <= fits ? CW'(trial - {1'b0, d}) : trial[CW-1:0];
        q        <= {q[NW-2:0], fits};
        dividend <= dividend << 1;
        cnt      <= cnt - SW'(1);
      end
      default: ;
    endcase
  end

endmodule

FILE: design/cmeb_outq.sv
// ----------------------------------------------------------------------------
// cmeb_outq
// Two-entry result queue between the builder and the output channel.
// ----------------------------------------------------------------------------
module cmeb_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cmeb_pkg::item_t push_item,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output cmeb_pkg::item_t out_item
);
  import cmeb_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = out_valid && !out_stall;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) count_next = count + 2'd1;
    if (!do_push && do_pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

FILE: design/cmeb_builder.sv
// ----------------------------------------------------------------------------
// cmeb_builder
// Back end: root choice, greedy chain build over pair counts, result issue.
// ----------------------------------------------------------------------------
module cmeb_builder #(
  parameter int MAX_VARS = cmeb_pkg::MAX_VARS_DEF,
  parameter int MAX_ROWS = cmeb_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [$clog2(MAX_ROWS+1)-1:0]         n_rows,
  input  logic [$clog2(MAX_VARS+1)-1:0]         nv,
  input  logic [16:0]                           lo,
  input  logic [16:0]                           hi,
  output logic [(MAX_ROWS>1 ? $clog2(MAX_ROWS) : 1)-1:0] row_raddr,
  input  logic [63:0]                           row_rdata,
  output logic                                  busy,
  input  logic                                  q_full,
  output logic                                  push,
  output cmeb_pkg::item_t                       push_item
);
  import cmeb_pkg::*;

  localparam int VW = $clog2(MAX_VARS);
  localparam int IW = $clog2(MAX_VARS + 1);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW = (CW > 1) ? $clog2(CW) : 1;
  localparam int FW = CW + KW + 31 - 14;
  localparam int HW = FW + 3;

  bld_state_t state;
  bld_state_t state_next;

  logic [CW-1:0] n;
  logic [CW-1:0] r;
  logic          pend;
  logic [VW-1:0] a_var;
  logic [VW-1:0] b_var;
  logic [CW-1:0] t00, t01, t10, t11;
  logic [CW-1:0] c0, c1;
  logic          scan_done;
  logic          bx, by;

  logic [IW-1:0] v;
  logic [CW-1:0] best_d;
  logic [VW-1:0] root;
  logic [CW-1:0] root_ones;
  logic [CW-1:0] d_cur;
  logic [IW-1:0] k;

  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [VW-1:0] prev;
  logic [VW-1:0] co_i;
  logic [2:0]    ent_sel;
  logic signed [HW-1:0] h;
  logic signed [HW-1:0] h_clip;
  logic signed [HW-1:0] best_h;
  logic [IW-1:0] best_j;
  logic [VW-1:0] best_var;
  logic [CW-1:0] bt01, bc0, bt11, bc1;
  logic [16:0]   p0, p1;

  logic [VW-1:0] co_mem [MAX_VARS];
  logic          co_we;
  logic [VW-1:0] co_waddr;
  logic [VW-1:0] co_wdata;
  logic [VW-1:0] co_raddr;
  logic [VW-1:0] co_rdata;

  logic          xl_start;
  logic [CW-1:0] xl_x;
  logic          xl_done;
  logic [FW-1:0] xl_res;
  logic          dv_start;
  logic [CW-1:0] dv_num;
  logic [CW-1:0] dv_den;
  logic          dv_done;
  logic [16:0]   dv_quo;
  logic signed [HW-1:0] f_ext;

  cmeb_xlnx #(.CW(CW)) u_xlnx (
    .clk(clk), .rst(rst), .start(xl_start), .x(xl_x), .done(xl_done), .result(xl_res)
  );

  cmeb_div #(.CW(CW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  assign c0        = t00 + t01;
  assign c1        = t10 + t11;
  assign scan_done = (r == n) && !pend;
  assign bx        = row_rdata[a_var];
  assign by        = row_rdata[b_var];
  assign d_cur     = (t11 < (n - t11)) ? t11 : (n - t11);
  assign h_clip    = h[HW-1] ? '0 : h;
  assign f_ext     = $signed(HW'(xl_res));
  assign busy      = (state != B_IDLE);
  assign row_raddr = r[RW-1:0];

  always_ff @(posedge clk) begin
    if (co_we) co_mem[co_waddr] <= co_wdata;
    co_rdata <= co_mem[co_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:          if (start) state_next = B_ROOT_NEXT;
      B_ROOT_NEXT:     state_next = (v < nv) ? B_ROOT_SCAN : B_INIT;
      B_ROOT_SCAN:     if (scan_done) state_next = B_ROOT_EVAL;
      B_ROOT_EVAL:     state_next = B_ROOT_NEXT;
      B_INIT:          if (k == IW'(MAX_VARS - 1)) state_next = B_ROOT_DIV;
      B_ROOT_DIV:      state_next = B_ROOT_DIV_WAIT;
      B_ROOT_DIV_WAIT: if (dv_done) state_next = B_ROOT_EMIT;
      B_ROOT_EMIT:     if (!q_full) state_next = B_NEXT_J;
      B_NEXT_J:        state_next = (j < nv) ? B_RD_WAIT : B_DIV0;
      B_RD_WAIT:       state_next = B_PAIR_SCAN;
      B_PAIR_SCAN:     if (scan_done) state_next = B_ENT;
      B_ENT:           state_next = B_ENT_WAIT;
      B_ENT_WAIT:      if (xl_done) state_next = (ent_sel == 3'd5) ? B_CAND : B_ENT;
      B_CAND:          state_next = B_NEXT_J;
      B_DIV0:          state_next = B_DIV0_WAIT;
      B_DIV0_WAIT:     if (dv_done) state_next = B_DIV1;
      B_DIV1:          state_next = B_DIV1_WAIT;
      B_DIV1_WAIT:     if (dv_done) state_next = B_SWAP_I;
      B_SWAP_I:        state_next = B_SWAP_C;
      B_SWAP_C:        state_next = B_EMIT;
      B_EMIT: begin
        if (!q_full) state_next = (i == nv - IW'(1)) ? B_IDLE : B_NEXT_J;
      end
      default:         state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    co_we     = 1'b0;
    co_waddr  = '0;
    co_wdata  = '0;
    co_raddr  = j[VW-1:0];
    xl_start  = 1'b0;
    xl_x      = t11;
    dv_start  = 1'b0;
    dv_num    = bt01;
    dv_den    = bc0;
    push      = 1'b0;
    push_item = '0;
    case (state)
      B_INIT: begin
        co_we    = 1'b1;
        co_waddr = k[VW-1:0];
        if (k == '0) co_wdata = root;
        else if (k[VW-1:0] == root) co_wdata = '0;
        else co_wdata = k[VW-1:0];
      end
      B_ROOT_DIV: begin
        dv_start = 1'b1;
        dv_num   = root_ones;
        dv_den   = n;
      end
      B_ROOT_EMIT: begin
        push               = 1'b1;
        push_item.position = '0;
        push_item.variable = 6'(root);
        push_item.p_zero   = clip_q16(p0, lo, hi);
        push_item.p_one    = clip_q16(p0, lo, hi);
        push_item.last     = 1'b0;
      end
      B_ENT: begin
        xl_start = 1'b1;
        case (ent_sel)
          3'd0:    xl_x = c0;
          3'd1:    xl_x = c1;
          3'd2:    xl_x = t00;
          3'd3:    xl_x = t01;
          3'd4:    xl_x = t10;
          default: xl_x = t11;
        endcase
      end
      B_DIV0: dv_start = 1'b1;
      B_DIV1: begin
        dv_start = 1'b1;
        dv_num   = bt11;
        dv_den   = bc1;
      end
      B_SWAP_I: begin
        co_we    = 1'b1;
        co_waddr = i[VW-1:0];
        co_wdata = best_var;
      end
      B_SWAP_C: begin
        co_we    = 1'b1;
        co_waddr = best_j[VW-1:0];
        co_wdata = co_i;
      end
      B_EMIT: begin
        push               = 1'b1;
        push_item.position = 6'(i);
        push_item.variable = 6'(best_var);
        push_item.p_zero   = clip_q16(p0, lo, hi);
        push_item.p_one    = clip_q16(p1, lo, hi);
        push_item.last     = (i == nv - IW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        n <= n_rows;
        v <= '0;
      end
      B_ROOT_NEXT: begin
        a_var <= v[VW-1:0];
        b_var <= v[VW-1:0];
        r     <= '0;
        pend  <= 1'b0;
        {t00, t01, t10, t11} <= '0;
        k     <= '0;
      end
      B_ROOT_SCAN, B_PAIR_SCAN: begin
        if (pend) begin
          case ({bx, by})
            2'b00:   t00 <= t00 + CW'(1);
            2'b01:   t01 <= t01 + CW'(1);
            2'b10:   t10 <= t10 + CW'(1);
            default: t11 <= t11 + CW'(1);
          endcase
        end
        if (r != n) begin
          r    <= r + CW'(1);
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      B_ROOT_EVAL: begin
        // ones count sits in t11 since both taps read the same variable
        if (v == '0 || d_cur < best_d) begin
          best_d    <= d_cur;
          root      <= v[VW-1:0];
          root_ones <= t11;
        end
        v <= v + IW'(1);
      end
      B_INIT: k <= k + IW'(1);
      B_ROOT_DIV_WAIT: if (dv_done) p0 <= dv_quo;
      B_ROOT_EMIT: begin
        prev <= root;
        i    <= IW'(1);
        j    <= IW'(1);
      end
      B_NEXT_J: a_var <= prev;
      B_RD_WAIT: begin
        b_var <= co_rdata;
        if (j == i) co_i <= co_rdata;
        r    <= '0;
        pend <= 1'b0;
        {t00, t01, t10, t11} <= '0;
        ent_sel <= '0;
        h    <= '0;
      end
      B_ENT_WAIT: begin
        if (xl_done) begin
          h       <= (ent_sel < 3'd2) ? h + f_ext : h - f_ext;
          ent_sel <= ent_sel + 3'd1;
        end
      end
      B_CAND: begin
        if (j == i || h_clip < best_h) begin
          best_h   <= h_clip;
          best_j   <= j;
          best_var <= b_var;
          bt01     <= t01;
          bc0      <= c0;
          bt11     <= t11;
          bc1      <= c1;
        end
        j <= j + IW'(1);
      end
      B_DIV0_WAIT: if (dv_done) p0 <= dv_quo;
      B_DIV1_WAIT: if (dv_done) p1 <= dv_quo;
      B_EMIT: begin
        if (!q_full) begin
          prev <= best_var;
          i    <= i + IW'(1);
          j    <= i + IW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
